>>> hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned OCC_W  = 6;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_DUMP   = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_APPLY,
		FSM_DUMP
	} fsm_t;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_DELETE,
		CMD_ROTATE
	} cell_cmd_t;

	// Broadcast control from the sequencer to every cell of the chain.
	typedef struct packed {
		logic                      cmp_en;
		cell_cmd_t                 cmd;
		logic signed [DATA_W-1:0]  value;
	} cell_ctrl_t;

endpackage

>>> hdl/spq_if.sv
// Request and result channel interfaces of the sorted priority queue.
interface spq_req_if;
	import spq_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [1:0]               op;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink (input valid, input op, input value, output ready);
endinterface

interface spq_rsp_if;
	import spq_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] entry;
	logic                     last;
	logic [OCC_W-1:0]         occupancy;

	modport source (output valid, output status, output entry, output last,
		output occupancy, input ready);
	modport sink (input valid, input status, input entry, input last,
		input occupancy, output ready);
endinterface

>>> hdl/spq_cell.sv
// One storage cell of the sorted chain: holds an entry and its compare flags.
module spq_cell
	import spq_pkg::*;
(
	input  logic                     clk,
	input  cell_ctrl_t               ctrl,
	input  logic                     found,
	input  logic                     self_valid,
	input  logic                     left_valid,
	input  logic                     left_ge,
	input  logic signed [DATA_W-1:0] left_entry,
	input  logic signed [DATA_W-1:0] right_entry,
	output logic signed [DATA_W-1:0] entry,
	output logic                     ge,
	output logic                     eq
);

	logic signed [DATA_W-1:0] entry_q;
	logic                     ge_q;
	logic                     eq_q;

	// Compare the request value against the held entry.
	always_ff @(posedge clk) begin
		if (ctrl.cmp_en) begin
			ge_q <= (ctrl.value >= entry_q);
			eq_q <= (ctrl.value == entry_q);
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			CMD_INSERT: begin
				// shift right behind the insert point, take the value at it
				if (left_valid && left_ge) begin
					entry_q <= left_entry;
				end else if (!self_valid || ge_q) begin
					entry_q <= ctrl.value;
				end
			end
			CMD_DELETE: begin
				if (found && self_valid && ge_q) begin
					entry_q <= right_entry;
				end
			end
			CMD_ROTATE: begin
				entry_q <= right_entry;
			end
			default: begin
			end
		endcase
	end

	assign entry = entry_q;
	assign ge    = ge_q;
	assign eq    = eq_q;

endmodule

>>> hdl/sorted_priority_queue_unit.sv
// Sorted priority queue: a chain of CAPACITY cells keeps signed 32-bit values
// largest first. For an insert or delete, the accept cycle loads the value and
// every cell compares it against its entry; the apply state then shifts the
// chain right (insert) or left (delete) in one step and posts one result once
// the result register is free. A dump passes through the apply state, then
// rotates the chain one place per cycle while the result side takes results
// and streams the head cell, one result per stored entry. Only one request is
// in work at a time. Results leave through a register, so a finished result
// may wait while the next request is taken. Contents of cells past the fill
// count are never shown.
module sorted_priority_queue_unit
	import spq_pkg::*;
#(
	parameter int unsigned CAPACITY = 32
) (
	input  logic clk,
	input  logic arst_n,
	spq_req_if.sink   request,
	spq_rsp_if.source result
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	fsm_t             state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] idx_q;
	op_t              op_q;
	logic signed [DATA_W-1:0] value_q;

	cell_ctrl_t       ctrl;
	logic [CAPACITY-1:0] valid_w, ge_w, eq_w;
	logic signed [DATA_W-1:0] entry_w [CAPACITY];
	logic             found;
	logic             accept;
	logic             out_free;
	logic             dump_last;

	// result register
	logic             rsp_valid_q;
	status_t          rsp_status_q;
	logic signed [DATA_W-1:0] rsp_entry_q;
	logic             rsp_last_q;
	logic [CNT_W-1:0] rsp_count_q;
	logic [CNT_W+OCC_W-1:0] occ_wide;

	// sequencer outputs
	logic             emit;
	status_t          emit_status;
	logic signed [DATA_W-1:0] emit_entry;
	logic             emit_last;
	cell_cmd_t        cmd;

	assign request.ready = (state_q == FSM_IDLE);
	assign accept        = request.valid && request.ready;
	assign out_free      = !rsp_valid_q || result.ready;
	assign found         = |(eq_w & valid_w);
	assign dump_last     = (idx_q == count_q - CNT_W'(1));

	// Compare on the accept cycle against the incoming value; otherwise the
	// held value drives insert.
	always_comb begin
		ctrl.cmp_en = accept;
		ctrl.cmd    = cmd;
		ctrl.value  = accept ? request.value : value_q;
	end

	// Cell chain. Valid bits form a thermometer of the fill count.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                     left_valid, left_ge;
		logic signed [DATA_W-1:0] left_entry, right_entry;

		assign valid_w[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_valid = 1'b0;
			assign left_ge    = 1'b0;
			assign left_entry = '0;
		end else begin : g_body
			assign left_valid = valid_w[i-1];
			assign left_ge    = ge_w[i-1];
			assign left_entry = entry_w[i-1];
		end

		// Past the last valid cell, wrap to the head so a dump rotates.
		if (i == CAPACITY - 1) begin : g_tail
			assign right_entry = entry_w[0];
		end else begin : g_mid
			assign right_entry = valid_w[i+1] ? entry_w[i+1] : entry_w[0];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.found      (found),
			.self_valid (valid_w[i]),
			.left_valid (left_valid),
			.left_ge    (left_ge),
			.left_entry (left_entry),
			.right_entry(right_entry),
			.entry      (entry_w[i]),
			.ge         (ge_w[i]),
			.eq         (eq_w[i])
		);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					state_d = FSM_APPLY;
				end
			end
			FSM_APPLY: begin
				if (op_q == OP_UNUSED) begin
					state_d = FSM_IDLE;
				end else if (out_free) begin
					if (op_q == OP_DUMP && count_q != '0) begin
						state_d = FSM_DUMP;
					end else begin
						state_d = FSM_IDLE;
					end
				end
			end
			FSM_DUMP: begin
				if (out_free && dump_last) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// Sequencer outputs: chain command, result to post, new fill count.
	always_comb begin
		cmd         = CMD_HOLD;
		emit        = 1'b0;
		emit_status = ST_OK;
		emit_entry  = '0;
		emit_last   = 1'b1;
		count_d     = count_q;
		case (state_q)
			FSM_APPLY: begin
				if (op_q != OP_UNUSED && out_free) begin
					emit = 1'b1;
					case (op_q)
						OP_INSERT: begin
							if (count_q == CAP_CNT) begin
								emit_status = ST_FULL;
							end else begin
								cmd     = CMD_INSERT;
								count_d = count_q + CNT_W'(1);
							end
						end
						OP_DELETE: begin
							if (count_q == '0) begin
								emit_status = ST_EMPTY;
							end else if (!found) begin
								emit_status = ST_NOT_FOUND;
							end else begin
								cmd     = CMD_DELETE;
								count_d = count_q - CNT_W'(1);
							end
						end
						OP_DUMP: begin
							// a non-empty dump streams from the dump state
							if (count_q == '0) begin
								emit_status = ST_EMPTY;
							end else begin
								emit = 1'b0;
							end
						end
						default: begin
							emit = 1'b0;
						end
					endcase
				end
			end
			FSM_DUMP: begin
				if (out_free) begin
					emit       = 1'b1;
					emit_entry = entry_w[0];
					emit_last  = dump_last;
					cmd        = CMD_ROTATE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			// advance the dump index per streamed entry, clear it otherwise
			if (state_q == FSM_DUMP) begin
				if (emit) begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end else begin
				idx_q <= '0;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (result.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Hold the request payload for the apply state.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(request.op);
			value_q <= request.value;
		end
	end

	// Load the result register; occupancy reports the count after the op.
	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_status_q <= emit_status;
			rsp_entry_q  <= emit_entry;
			rsp_last_q   <= emit_last;
			rsp_count_q  <= count_d;
		end
	end

	assign occ_wide         = {{OCC_W{1'b0}}, rsp_count_q};
	assign result.valid     = rsp_valid_q;
	assign result.status    = rsp_status_q;
	assign result.entry     = rsp_entry_q;
	assign result.last      = rsp_last_q;
	assign result.occupancy = occ_wide[OCC_W-1:0];

endmodule

>>> dv/spq_tb_pkg.sv
// Result bookkeeping class that predicts and checks the sorted priority queue.
package spq_tb_pkg;
	import spq_pkg::*;

	localparam int unsigned MAX_REPORTS = 40;

	typedef struct {
		status_t                  status;
		logic signed [DATA_W-1:0] entry;
		logic                     last;
		logic [OCC_W-1:0]         occupancy;
	} queue_result_t;

	class spq_order_checker;
		logic signed [DATA_W-1:0] stored[$];
		queue_result_t            awaited[$];
		int unsigned              depth;
		int unsigned              errors;

		function new(int unsigned depth_i);
			depth  = depth_i;
			errors = 0;
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		// Queue one result; occupancy is the fill after the operation.
		function void post(status_t status, logic signed [DATA_W-1:0] entry, logic last);
			queue_result_t r;
			r.status    = status;
			r.entry     = entry;
			r.last      = last;
			r.occupancy = OCC_W'(stored.size());
			awaited.push_back(r);
		endfunction

		// Apply one accepted request to the shadow store and queue its results.
		function void note_request(op_t op, logic signed [DATA_W-1:0] value);
			int pos;
			case (op)
				OP_INSERT: begin
					if (stored.size() >= depth) begin
						post(ST_FULL, '0, 1'b1);
					end else begin
						// first entry less than or equal to the value, largest first
						pos = stored.size();
						for (int i = stored.size() - 1; i >= 0; i--)
							if (value >= stored[i])
								pos = i;
						stored.insert(pos, value);
						post(ST_OK, '0, 1'b1);
					end
				end
				OP_DELETE: begin
					if (stored.size() == 0) begin
						post(ST_EMPTY, '0, 1'b1);
					end else begin
						pos = stored.size();
						for (int i = stored.size() - 1; i >= 0; i--)
							if (stored[i] === value)
								pos = i;
						if (pos == stored.size()) begin
							post(ST_NOT_FOUND, '0, 1'b1);
						end else begin
							stored.delete(pos);
							post(ST_OK, '0, 1'b1);
						end
					end
				end
				OP_DUMP: begin
					if (stored.size() == 0)
						post(ST_EMPTY, '0, 1'b1);
					else
						foreach (stored[i])
							post(ST_OK, stored[i], i == stored.size() - 1);
				end
				default: begin
				end
			endcase
		endfunction

		function void compare(realtime now, string field, logic signed [DATA_W-1:0] want,
			logic signed [DATA_W-1:0] got);
			if (got !== want) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0.1f ns: %s mismatch, expected %0d, actual %0d",
						now, field, want, got);
			end
		endfunction

		// Compare one accepted result with the oldest outstanding one.
		function void check_result(logic [1:0] status, logic signed [DATA_W-1:0] entry,
			logic last, logic [OCC_W-1:0] occupancy, realtime now);
			queue_result_t want;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0.1f ns: result with none outstanding, expected nothing, actual status %0d entry %0d last %0d occupancy %0d",
						now, status, entry, last, occupancy);
				return;
			end
			want = awaited.pop_front();
			compare(now, "status", {30'd0, want.status}, {30'd0, status});
			compare(now, "entry", want.entry, entry);
			compare(now, "last", {31'd0, want.last}, {31'd0, last});
			compare(now, "occupancy", {26'd0, want.occupancy}, {26'd0, occupancy});
		endfunction
	endclass

endpackage

>>> dv/tb_sorted_priority_queue_unit.sv
// Self-checking testbench of the sorted priority queue unit.
module tb_sorted_priority_queue_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;
	import spq_tb_pkg::*;

	localparam int unsigned CAPACITY     = 32;
	localparam int unsigned RANDOM_ITEMS = 350;
	// A dump streams up to CAPACITY entries; the drain wait after the last result allows for that.
	localparam int unsigned DRAIN_CYCLES = 2 * CAPACITY + 8;
	localparam int unsigned HOLD_CYCLES  = 200;
	localparam int unsigned LIMIT_CYCLES = 1_000_000;

	logic clk;
	logic arst_n;

	spq_req_if request ();
	spq_rsp_if result ();

	sorted_priority_queue_unit #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request),
		.result (result)
	);

	spq_order_checker book = new(CAPACITY);

	// Requests left in the current sender burst; zero starts a gap.
	int unsigned burst_left = 0;
	// Set by the stimulus, cleared by the receiver once its long hold-off is over.
	bit hold_results = 1'b0;
	longint unsigned cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Stop a hung run; this also covers results that never arrive.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("sorted_priority_queue_unit verification failed");
			$finish;
		end
	end

	// Check every result taken by the receiver at the rising edge.
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready)
			book.check_result(result.status, result.entry, result.last, result.occupancy,
				$realtime);
	end

	// Offer one request and hold it until the block takes it. Insert a random gap
	// whenever the current burst runs out, so gaps land on every phase of the work.
	task automatic send_request(op_t op, logic signed [DATA_W-1:0] value);
		if (burst_left == 0) begin
			@(negedge clk);
			request.valid <= 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
			// mostly short bursts, sometimes a long stretch with no idling
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) :
				$urandom_range(1, 8);
		end
		burst_left--;
		@(negedge clk);
		request.valid <= 1'b1;
		request.op    <= op;
		request.value <= value;
		do
			@(posedge clk);
		while (!request.ready);
		book.note_request(op, value);
	endtask

	// Draw a value: small values give many duplicates, extremes hit the sign edges,
	// full-width values toggle every bit.
	function automatic logic signed [DATA_W-1:0] pick_value();
		logic signed [DATA_W-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $signed($urandom_range(0, 8)) - 4;
			4: begin
				case ($urandom_range(0, 3))
					0: v = 32'sh7fff_ffff;
					1: v = 32'sh8000_0000;
					2: v = '0;
					default: v = -1;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Mostly delete something that is stored, else probe for a miss.
	function automatic logic signed [DATA_W-1:0] pick_delete_value();
		if (book.stored.size() != 0 && $urandom_range(0, 3) != 0)
			return book.stored[$urandom_range(0, book.stored.size() - 1)];
		return pick_value();
	endfunction

	// Receiver: ready follows a pattern of its own, in episodes of random length.
	initial begin : receiver
		int unsigned mode;
		int unsigned span;
		result.ready = 1'b0;
		forever begin
			if (hold_results) begin
				// Hold off for a long stretch so the result register stays full and the block stalls its input.
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					result.ready <= 1'b0;
				end
				hold_results = 1'b0;
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(5, 40);
				for (int c = 0; c < span; c++) begin
					@(negedge clk);
					case (mode)
						0: result.ready <= 1'b1;
						1: result.ready <= 1'($urandom_range(0, 1));
						2: result.ready <= ($urandom_range(0, 3) == 0);
						default: result.ready <= (c % 3 != 0);
					endcase
				end
			end
		end
	end

	initial begin : stimulus
		int unsigned counted;
		int unsigned segment;
		int unsigned kind;
		int unsigned len;
		int unsigned roll;
		int unsigned ins_lim;
		int unsigned del_lim;
		int unsigned dump_lim;

		request.valid = 1'b0;
		request.op    = OP_INSERT;
		request.value = '0;
		arst_n        = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty cases, unused op code, sign extremes, ties, misses.
		send_request(OP_DUMP, 32'sd17);
		send_request(OP_DELETE, 32'sd0);
		send_request(OP_UNUSED, $urandom);
		send_request(OP_INSERT, 32'sd0);
		send_request(OP_INSERT, 32'sh7fff_ffff);
		send_request(OP_INSERT, 32'sh8000_0000);
		send_request(OP_INSERT, -32'sd1);
		send_request(OP_INSERT, 32'sd1);
		send_request(OP_INSERT, 32'sd0);
		send_request(OP_DUMP, '0);
		send_request(OP_DELETE, 32'sd5);
		send_request(OP_DELETE, 32'sh8000_0000);
		send_request(OP_DELETE, 32'sd0);
		send_request(OP_DELETE, 32'sh7fff_ffff);
		send_request(OP_UNUSED, 32'shffff_ffff);
		send_request(OP_DUMP, 32'shffff_ffff);
		send_request(OP_DELETE, -32'sd1);
		send_request(OP_DELETE, 32'sd1);
		send_request(OP_DELETE, 32'sd0);
		send_request(OP_DUMP, '0);

		// Random: segments that grow, shrink or churn the store, so it runs through
		// full and empty repeatedly. Ignored op codes do not count.
		counted = 0;
		segment = 0;
		while (counted < RANDOM_ITEMS) begin
			kind = (segment == 0) ? 0 : $urandom_range(0, 2);
			len  = (segment == 0) ? 50 : $urandom_range(25, 50);
			case (kind)
				0: begin ins_lim = 85; del_lim = 93; dump_lim = 98; end
				1: begin ins_lim = 15; del_lim = 85; dump_lim = 96; end
				default: begin ins_lim = 40; del_lim = 80; dump_lim = 96; end
			endcase
			// Start the long receiver hold-off once, right after the first, growing segment.
			if (segment == 1)
				hold_results = 1'b1;
			for (int k = 0; k < len && counted < RANDOM_ITEMS; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < ins_lim) begin
					send_request(OP_INSERT, pick_value());
					counted++;
				end else if (roll < del_lim) begin
					send_request(OP_DELETE, pick_delete_value());
					counted++;
				end else if (roll < dump_lim) begin
					send_request(OP_DUMP, $urandom);
					counted++;
				end else begin
					send_request(OP_UNUSED, $urandom);
				end
			end
			segment++;
		end

		@(negedge clk);
		request.valid <= 1'b0;

		// Drain outstanding results, then give stray results time to show up.
		while (book.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (book.errors == 0)
			$display("sorted_priority_queue_unit verification clean");
		else
			$display("sorted_priority_queue_unit verification failed");
		$finish;
	end

endmodule
